// ===== rtl/core/array_list_insert_delete_assert.svh =====
// Assertion macros for the array list block.
// Expects clk and rst_n in the scope of each use.
`ifndef ARRAY_LIST_INSERT_DELETE_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_ASSERT_SVH

// check cons in the same cycle as ante
`define ALID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define ALID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/alid_pkg.sv =====
// Shared types, codes and sizes of the array list block.
// No dependencies; used by the controller, the datapath and the top level.
package alid_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CMD_W      = 2;
    localparam int POS_W      = 7;
    localparam int ST_W       = 2;
    localparam int CNT_OUT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [POS_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] item_in;
    } cmd_item_t;

    typedef struct packed {
        logic [ST_W-1:0]       status;
        logic [DATA_WIDTH-1:0] item_out;
        logic [CNT_OUT_W-1:0]  count;
        logic                  is_empty;
    } rsp_item_t;

    typedef struct packed {
        logic            load;
        logic            init_ins;
        logic            init_del;
        logic            shift_ins;
        logic            shift_del;
        logic            put;
        logic            capture;
        logic            set_status;
        logic [ST_W-1:0] status;
        logic            finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             ins_pos_ok;
        logic             acc_pos_ok;
        logic             ins_busy;
        logic             del_busy;
        logic             out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/alid_ctrl.sv =====
// Command sequencer of the array list block.
// Depends on alid_pkg; drives the datapath through ctl_cmd_t, reads dp_stat_t.
module alid_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  alid_pkg::dp_stat_t  stat,
    output alid_pkg::ctl_cmd_t  ctl
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_INS_SHIFT = 3'd2;
    localparam logic [2:0] S_INS_PUT   = 3'd3;
    localparam logic [2:0] S_CAPTURE   = 3'd4;
    localparam logic [2:0] S_DEL_SHIFT = 3'd5;
    localparam logic [2:0] S_RESULT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.set_status = 1'b1;
                ctl.status     = alid_pkg::ST_BADPOS;
                state_next     = S_RESULT;
                case (stat.cmd)
                    alid_pkg::CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            ctl.status = alid_pkg::ST_FULL;
                        end
                        else if (stat.ins_pos_ok)
                        begin
                            ctl.set_status = 1'b0;
                            ctl.init_ins   = 1'b1;
                            state_next     = S_INS_SHIFT;
                        end
                    end
                    alid_pkg::CMD_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            ctl.status = alid_pkg::ST_EMPTY;
                        end
                        else if (stat.acc_pos_ok)
                        begin
                            ctl.status   = alid_pkg::ST_OK;
                            ctl.init_del = 1'b1;
                            state_next   = S_CAPTURE;
                        end
                    end
                    alid_pkg::CMD_READ:
                    begin
                        if (stat.acc_pos_ok)
                        begin
                            ctl.status = alid_pkg::ST_OK;
                            state_next = S_CAPTURE;
                        end
                    end
                    default:
                    begin
                        ctl.status = alid_pkg::ST_BADPOS;
                    end
                endcase
            end
            S_INS_SHIFT:
            begin
                ctl.shift_ins = 1'b1;
                if (!stat.ins_busy)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                ctl.put        = 1'b1;
                ctl.set_status = 1'b1;
                ctl.status     = alid_pkg::ST_OK;
                state_next     = S_RESULT;
            end
            S_CAPTURE:
            begin
                ctl.capture = 1'b1;
                state_next  = (stat.cmd == alid_pkg::CMD_DELETE) ? S_DEL_SHIFT : S_RESULT;
            end
            S_DEL_SHIFT:
            begin
                ctl.shift_del = 1'b1;
                if (!stat.del_busy)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/alid_dpath.sv =====
// Datapath of the array list block: entry memory, count, shift pipeline, result register.
// Depends on alid_pkg and array_list_insert_delete_assert.svh; controlled by alid_ctrl.
`include "array_list_insert_delete_assert.svh"

module alid_dpath #(
    parameter int LIST_DEPTH = alid_pkg::LIST_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  alid_pkg::cmd_item_t cmd_data,
    input  alid_pkg::ctl_cmd_t  ctl,
    output alid_pkg::dp_stat_t  stat,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output alid_pkg::rsp_item_t rsp_data
);

    localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > alid_pkg::POS_W) ? CNT_W : alid_pkg::POS_W) + 1;
    localparam int DW    = alid_pkg::DATA_WIDTH;

    logic [DW-1:0] mem [LIST_DEPTH];

    logic [alid_pkg::CMD_W-1:0] cmd_reg;
    logic [alid_pkg::POS_W-1:0] pos_reg;
    logic [DW-1:0]              val_reg;
    logic [DW-1:0]              rdata_reg;
    logic [DW-1:0]              item_reg;
    logic [alid_pkg::ST_W-1:0]  status_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           idx_reg;
    logic [CNT_W-1:0]           idx_next;
    logic                       pend_reg;
    logic                       pend_next;
    logic [AW-1:0]              wr_addr_reg;
    logic [AW-1:0]              wr_addr_next;
    logic                       rsp_valid_reg;
    alid_pkg::rsp_item_t        rsp_data_reg;

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] idx_c;
    logic [CMP_W-1:0] pos_m1;
    logic             ins_rd;
    logic             del_rd;
    logic [AW-1:0]    raddr;
    logic             wen;
    logic [AW-1:0]    waddr;
    logic [DW-1:0]    wdata;
    logic             out_free;

    assign pos_c  = CMP_W'(pos_reg);
    assign cnt_c  = CMP_W'(count_reg);
    assign idx_c  = CMP_W'(idx_reg);
    assign pos_m1 = pos_c - CMP_W'(1);
    assign ins_rd = (idx_c >= pos_c);
    assign del_rd = (idx_c < cnt_c);

    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign stat.cmd        = cmd_reg;
    assign stat.full       = (count_reg == CNT_W'(LIST_DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1));
    assign stat.acc_pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
    assign stat.ins_busy   = ins_rd || pend_reg;
    assign stat.del_busy   = del_rd || pend_reg;
    assign stat.out_free   = out_free;

    always_comb
    begin
        raddr        = AW'(pos_m1);
        pend_next    = 1'b0;
        wr_addr_next = wr_addr_reg;
        idx_next     = idx_reg;
        if (ctl.init_ins)
        begin
            idx_next = count_reg;
        end
        else if (ctl.init_del)
        begin
            idx_next = CNT_W'(pos_reg);
        end
        else if (ctl.shift_ins && ins_rd)
        begin
            raddr        = AW'(idx_reg - CNT_W'(1));
            pend_next    = 1'b1;
            wr_addr_next = AW'(idx_reg);
            idx_next     = idx_reg - CNT_W'(1);
        end
        else if (ctl.shift_del && del_rd)
        begin
            raddr        = AW'(idx_reg);
            pend_next    = 1'b1;
            wr_addr_next = AW'(idx_reg - CNT_W'(1));
            idx_next     = idx_reg + CNT_W'(1);
        end
    end

    assign wen   = pend_reg || ctl.put;
    assign waddr = ctl.put ? AW'(pos_m1) : wr_addr_reg;
    assign wdata = ctl.put ? val_reg : rdata_reg;

    always_comb
    begin
        count_next = count_reg;
        if (status_reg == alid_pkg::ST_OK)
        begin
            if (cmd_reg == alid_pkg::CMD_INSERT)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (cmd_reg == alid_pkg::CMD_DELETE)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        wr_addr_reg <= wr_addr_next;
        if (ctl.load)
        begin
            cmd_reg  <= cmd_data.cmd;
            pos_reg  <= cmd_data.pos;
            val_reg  <= cmd_data.item_in;
            item_reg <= '0;
        end
        else if (ctl.capture)
        begin
            item_reg <= rdata_reg;
        end
        if (ctl.set_status)
        begin
            status_reg <= ctl.status;
        end
        if (ctl.finish)
        begin
            rsp_data_reg.status   <= status_reg;
            rsp_data_reg.item_out <= item_reg;
            rsp_data_reg.count    <= alid_pkg::CNT_OUT_W'(count_next);
            rsp_data_reg.is_empty <= (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (ctl.finish)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    `ALID_ASSERT_NOW(a_cnt_range, 1'b1, cnt_c <= CMP_W'(LIST_DEPTH), "count above depth")
    `ALID_ASSERT_NOW(a_put_alone, ctl.put, !pend_reg, "insert write collides with shift")
    `ALID_ASSERT_NOW(a_finish_free, ctl.finish, out_free, "result loaded over pending result")
    `ALID_ASSERT_NEXT(a_cnt_hold, !ctl.finish, $stable(count_reg), "count moved outside finish")

endmodule

// ===== rtl/core/array_list_insert_delete.sv =====
// Top level of the array list block: ordered list with insert, delete and read by position.
// Depends on alid_pkg, alid_ctrl and alid_dpath.
//
// Commands are taken one at a time and each gives one result. An insert passes through the
// check, a shift that moves the entries from position p on up by one, the write of the new
// entry and the result; a delete through the check, the capture of the entry at p, a shift
// that moves the later entries down by one and the result; a read through the check, the
// capture and the result. A command refused for a full, empty or bad position goes from the
// check to the result. The shift is paced by the entry memory, which has one write and one
// registered read port and so moves one entry a cycle while the later entries shift. A
// result sits in an output register, so a stalled result does not hold off acceptance of the
// next command; that command's result waits until the stalled one is taken.
module array_list_insert_delete #(
    parameter int LIST_DEPTH = alid_pkg::LIST_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  alid_pkg::cmd_item_t cmd_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output alid_pkg::rsp_item_t rsp_data
);

    alid_pkg::ctl_cmd_t ctl;
    alid_pkg::dp_stat_t stat;

    alid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    alid_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== bench/array_list_insert_delete_tb.sv =====
// Self-checking bench for array_list_insert_delete: a queue-fed driver, a checking monitor
// and a list predictor built on a SystemVerilog queue.
// Depends on alid_pkg and the array_list_insert_delete RTL only.
module array_list_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [alid_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 550;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum {PH_GROW, PH_MIX_HI, PH_SHRINK, PH_MIX_LO} phase_t;

    logic                logic_unused_guard;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    alid_pkg::cmd_item_t cmd_data = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    alid_pkg::rsp_item_t rsp_data;

    alid_pkg::cmd_item_t                 cmd_pending_q[$];
    alid_pkg::rsp_item_t                 rsp_expected_q[$];
    logic [alid_pkg::DATA_WIDTH-1:0]     list_model_q[$];

    int unsigned gen_len = 0;
    int unsigned drv_wait = 0;
    int unsigned drv_run = 0;
    int unsigned mon_wait = 0;
    int unsigned mon_run = 0;
    int unsigned idle_cycles = 0;
    int unsigned cmds_sent = 0;
    int unsigned rsps_seen = 0;
    int unsigned peak_len = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};
    int unsigned mismatches = 0;

    assign logic_unused_guard = 1'b0;

    array_list_insert_delete u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic alid_pkg::rsp_item_t list_apply(alid_pkg::cmd_item_t c);
        alid_pkg::rsp_item_t r;
        int unsigned         p;
        int unsigned         n;
        r = '0;
        r.status = alid_pkg::ST_BADPOS;
        p = 32'(c.pos);
        n = list_model_q.size();
        case (c.cmd)
            alid_pkg::CMD_INSERT:
            begin
                if (n >= alid_pkg::LIST_DEPTH)
                begin
                    r.status = alid_pkg::ST_FULL;
                end
                else if (p >= 1 && p <= n + 1)
                begin
                    list_model_q.insert(p - 1, c.item_in);
                    r.status = alid_pkg::ST_OK;
                end
            end
            alid_pkg::CMD_DELETE:
            begin
                if (n == 0)
                begin
                    r.status = alid_pkg::ST_EMPTY;
                end
                else if (p >= 1 && p <= n)
                begin
                    r.item_out = list_model_q[p - 1];
                    list_model_q.delete(p - 1);
                    r.status = alid_pkg::ST_OK;
                end
            end
            alid_pkg::CMD_READ:
            begin
                if (p >= 1 && p <= n)
                begin
                    r.item_out = list_model_q[p - 1];
                    r.status = alid_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        r.count = alid_pkg::CNT_OUT_W'(list_model_q.size());
        r.is_empty = (list_model_q.size() == 0);
        return r;
    endfunction

    function automatic int unsigned idle_draw(inout int unsigned run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            run = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // track the list length so that random positions land mostly in range
    task automatic queue_cmd(logic [alid_pkg::CMD_W-1:0] c, logic [alid_pkg::POS_W-1:0] p,
                             logic [alid_pkg::DATA_WIDTH-1:0] v);
        alid_pkg::cmd_item_t t;
        t.cmd = c;
        t.pos = p;
        t.item_in = v;
        cmd_pending_q.push_back(t);
        if (c == alid_pkg::CMD_INSERT && gen_len < alid_pkg::LIST_DEPTH && p >= 1 &&
            p <= gen_len + 1)
            gen_len++;
        else if (c == alid_pkg::CMD_DELETE && gen_len > 0 && p >= 1 && p <= gen_len)
            gen_len--;
    endtask

    function automatic logic [alid_pkg::POS_W-1:0] pick_pos(logic [alid_pkg::CMD_W-1:0] c);
        int unsigned top;
        int unsigned roll;
        top = (c == alid_pkg::CMD_INSERT) ? gen_len + 1 : gen_len;
        roll = $urandom_range(0, 99);
        if (top == 0 || roll < 12)
            return alid_pkg::POS_W'($urandom_range(0, 127));
        if (roll < 32)
            return alid_pkg::POS_W'(1);
        if (roll < 52)
            return alid_pkg::POS_W'(top);
        return alid_pkg::POS_W'($urandom_range(1, top));
    endfunction

    initial
    begin
        phase_t                     kind;
        int unsigned                tail;
        int unsigned                left;
        int unsigned                roll;
        logic [alid_pkg::CMD_W-1:0] c;

        queue_cmd(alid_pkg::CMD_READ,   7'd1,   32'h1234_5678);
        queue_cmd(alid_pkg::CMD_DELETE, 7'd1,   32'h0);
        queue_cmd(alid_pkg::CMD_DELETE, 7'd0,   32'h0);
        queue_cmd(alid_pkg::CMD_INSERT, 7'd0,   32'hDEAD_BEEF);
        queue_cmd(alid_pkg::CMD_INSERT, 7'd2,   32'hDEAD_BEEF);
        queue_cmd(alid_pkg::CMD_INSERT, 7'd127, 32'hDEAD_BEEF);
        queue_cmd(CMD_UNUSED,           7'd127, 32'hFFFF_FFFF);
        queue_cmd(alid_pkg::CMD_INSERT, 7'd1,   32'h0000_0000);
        queue_cmd(alid_pkg::CMD_INSERT, 7'd2,   32'hFFFF_FFFF);
        queue_cmd(alid_pkg::CMD_INSERT, 7'd1,   32'h5555_AAAA);
        queue_cmd(alid_pkg::CMD_INSERT, 7'd2,   32'hA5A5_5A5A);
        queue_cmd(alid_pkg::CMD_READ,   7'd1,   32'h0);
        queue_cmd(alid_pkg::CMD_READ,   7'd4,   32'h0);
        queue_cmd(alid_pkg::CMD_READ,   7'd5,   32'h0);
        queue_cmd(alid_pkg::CMD_READ,   7'd0,   32'h0);
        queue_cmd(alid_pkg::CMD_DELETE, 7'd5,   32'h0);
        queue_cmd(alid_pkg::CMD_DELETE, 7'd0,   32'h0);
        queue_cmd(alid_pkg::CMD_DELETE, 7'd2,   32'h0);
        queue_cmd(alid_pkg::CMD_DELETE, 7'd3,   32'h0);
        queue_cmd(alid_pkg::CMD_DELETE, 7'd1,   32'h0);
        queue_cmd(alid_pkg::CMD_DELETE, 7'd1,   32'h0);
        queue_cmd(CMD_UNUSED,           7'd0,   32'h0);

        kind = PH_GROW;
        tail = 0;
        left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            case (kind)
                PH_GROW:
                    c = roll < 75 ? alid_pkg::CMD_INSERT : roll < 85 ? alid_pkg::CMD_DELETE :
                        roll < 97 ? alid_pkg::CMD_READ : CMD_UNUSED;
                PH_SHRINK:
                    c = roll < 75 ? alid_pkg::CMD_DELETE : roll < 85 ? alid_pkg::CMD_INSERT :
                        roll < 97 ? alid_pkg::CMD_READ : CMD_UNUSED;
                default:
                    c = roll < 40 ? alid_pkg::CMD_INSERT : roll < 75 ? alid_pkg::CMD_DELETE :
                        roll < 97 ? alid_pkg::CMD_READ : CMD_UNUSED;
            endcase
            queue_cmd(c, pick_pos(c), $urandom());
            case (kind)
                PH_GROW:
                begin
                    if (gen_len == alid_pkg::LIST_DEPTH)
                        tail++;
                    if (tail == 6)
                    begin
                        kind = PH_MIX_HI;
                        left = 40;
                    end
                end
                PH_SHRINK:
                begin
                    if (gen_len == 0)
                        tail++;
                    if (tail == 6)
                    begin
                        kind = PH_MIX_LO;
                        left = 40;
                    end
                end
                default:
                begin
                    left--;
                    if (left == 0)
                    begin
                        kind = (kind == PH_MIX_HI) ? PH_SHRINK : PH_GROW;
                        tail = 0;
                    end
                end
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_data <= '0;
            drv_wait = 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                rsp_expected_q.push_back(list_apply(cmd_data));
                cmds_sent++;
                drv_wait = idle_draw(drv_run);
            end
            // hold a stalled transfer
            if (!(cmd_valid && cmd_stall))
            begin
                if (drv_wait == 0 && cmd_pending_q.size() > 0)
                begin
                    cmd_valid <= 1'b1;
                    cmd_data <= cmd_pending_q.pop_front();
                end
                else
                begin
                    cmd_valid <= 1'b0;
                    if (drv_wait > 0)
                        drv_wait--;
                end
            end
        end
    end

    task automatic check_field(string fname, logic [alid_pkg::DATA_WIDTH-1:0] exp_v,
                               logic [alid_pkg::DATA_WIDTH-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            mon_wait = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             rsp_data);
                    mismatches++;
                end
                else
                begin
                    alid_pkg::rsp_item_t e;
                    e = rsp_expected_q.pop_front();
                    check_field("status", alid_pkg::DATA_WIDTH'(e.status),
                                alid_pkg::DATA_WIDTH'(rsp_data.status));
                    check_field("item_out", e.item_out, rsp_data.item_out);
                    check_field("count", alid_pkg::DATA_WIDTH'(e.count),
                                alid_pkg::DATA_WIDTH'(rsp_data.count));
                    check_field("is_empty", alid_pkg::DATA_WIDTH'(e.is_empty),
                                alid_pkg::DATA_WIDTH'(rsp_data.is_empty));
                end
                rsps_seen++;
                status_seen[rsp_data.status]++;
                if (32'(rsp_data.count) > peak_len)
                    peak_len = 32'(rsp_data.count);
                // long hold-off lets the block back up into its input
                if (rsps_seen == 120 || rsps_seen == 400)
                    mon_wait = HOLD_CYCLES;
                else
                    mon_wait = idle_draw(mon_run);
            end
            else if (mon_wait > 0)
            begin
                mon_wait--;
            end
            rsp_stall <= (mon_wait != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!(cmd_pending_q.size() == 0 && !cmd_valid && rsp_expected_q.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d commands, checked %0d results; peak list length %0d of %0d.",
                 cmds_sent, rsps_seen, peak_len, alid_pkg::LIST_DEPTH);
        $display("Results by status: ok %0d, full %0d, empty %0d, bad position %0d.",
                 status_seen[alid_pkg::ST_OK], status_seen[alid_pkg::ST_FULL],
                 status_seen[alid_pkg::ST_EMPTY], status_seen[alid_pkg::ST_BADPOS]);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
